### rtl/ffc_pkg.sv
// Shared types and constants for the formation follower controller.
`timescale 1ns / 1ps
`default_nettype none

package ffc_pkg;

	// Reset value of the arrival radius in millimetres.
	localparam logic [15:0] TOL_RESET = 16'd300;

	// Item kinds on the command channel.
	typedef enum logic {
		OP_LEADER = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	// Follower modes.
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_MOVE = 2'd2,
		MODE_HOLD = 2'd3
	} mode_t;

	typedef logic signed [31:0] pos_t;
	typedef logic signed [32:0] off_t;
	typedef pos_t [2:0] vec3_t;

	// One command item.
	typedef struct packed {
		logic        opcode;
		logic [31:0] leader_x;
		logic [31:0] leader_y;
		logic [31:0] leader_z;
		logic        leader_locked;
		logic        leader_at_goal;
		logic [31:0] local_x;
		logic [31:0] local_y;
		logic [31:0] local_z;
		logic        local_valid;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  mode;
		logic        setpoint_valid;
		logic [31:0] target_x;
		logic [31:0] target_y;
		logic [31:0] target_z;
		logic        offset_held;
	} res_t;

endpackage

`default_nettype wire

### rtl/formation_follower_controller.sv
// Top level of the formation follower controller: input register, core and result register.
`timescale 1ns / 1ps
`default_nettype none

// Formation follower controller. Leader updates (opcode 0) store the leader
// position and flags and step the mode; ticks (opcode 1) with a known local
// position capture the formation offset in idle with a steady leader and command
// leader plus offset in move and hold, switching to hold on arrival. Each such
// tick, once a leader update has been seen, gives one result item; a leader
// update gives none. An item is registered in the input register on acceptance
// and processed once the result register can take it; one item is taken in every
// cycle while the result side keeps up, the rate being set by the update of the
// mode, leader and offset registers. The arrival radius is written through the
// configuration channel, which is always ready, and resets to 300 mm.
module formation_follower_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ffc_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output ffc_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);

	logic          valid_s1;
	ffc_pkg::cmd_t cmd_s1;
	logic          advance;
	logic          emit;
	ffc_pkg::res_t res_d;
	logic          res_valid_q;
	ffc_pkg::res_t res_q;

	// The held item goes through once the result register can take a result.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) cmd_s1 <= cmd;
	end

	ffc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid),
		.cfg_data (cfg_data),
		.commit   (advance),
		.cmd      (cmd_s1),
		.emit     (emit),
		.res      (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/ffc_arrival.sv
// Arrival test: squared distance from local position to setpoint against the tolerance.
`timescale 1ns / 1ps
`default_nettype none

module ffc_arrival (
	input  ffc_pkg::vec3_t local_pos,
	input  ffc_pkg::vec3_t target,
	input  logic [15:0]    tol,
	output logic           near
);

	logic [2:0][32:0] diff;
	logic [2:0][32:0] mag;
	logic [2:0]       far;
	logic [2:0][31:0] sq;
	logic [33:0]      sum;
	logic [31:0]      tol_sq;

	// Per-axis magnitude of the error and its square. An axis beyond the
	// radius fails the test outright, so only the low 16 bits need squaring.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {local_pos[i][31], local_pos[i]} - {target[i][31], target[i]};
			mag[i]  = diff[i][32] ? (~diff[i] + 33'd1) : diff[i];
			far[i]  = mag[i] > {17'd0, tol};
			sq[i]   = {16'd0, mag[i][15:0]} * {16'd0, mag[i][15:0]};
		end
	end

	// Sum of squares against the squared radius.
	always_comb begin
		tol_sq = {16'd0, tol} * {16'd0, tol};
		sum    = {2'd0, sq[0]} + {2'd0, sq[1]} + {2'd0, sq[2]};
		near   = (far == 3'd0) && (sum <= {2'd0, tol_sq});
	end

endmodule

`default_nettype wire

### rtl/ffc_core.sv
// Follower state, mode sequencing and setpoint arithmetic for one item per cycle while commit is high.
`timescale 1ns / 1ps
`default_nettype none

module ffc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr,
	input  logic [15:0]   cfg_data,
	input  logic          commit,
	input  ffc_pkg::cmd_t cmd,
	output logic          emit,
	output ffc_pkg::res_t res
);

	ffc_pkg::mode_t mode_q;
	ffc_pkg::mode_t mode_d;
	logic [15:0]    tol_q;
	logic           seen_q;
	logic           lock_q;
	logic           goal_q;
	logic           cap_q;
	logic           cap_d;
	ffc_pkg::vec3_t lead_q;
	ffc_pkg::off_t  off_q [3];
	ffc_pkg::off_t  off_new [3];
	ffc_pkg::vec3_t local_pos;
	ffc_pkg::vec3_t target;
	logic [33:0]    tsum [3];
	logic           is_tick;
	logic           steady_upd;
	logic           steady_st;
	logic           capture;
	logic           sp;
	logic           near;

	// Clamp a 34-bit sum to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

	// Decode of the item and the arithmetic that does not depend on the mode.
	always_comb begin
		is_tick    = cmd.opcode == ffc_pkg::OP_TICK;
		emit       = is_tick && cmd.local_valid && seen_q;
		steady_upd = cmd.leader_at_goal && !cmd.leader_locked;
		steady_st  = goal_q && !lock_q;
		local_pos  = {cmd.local_z, cmd.local_y, cmd.local_x};
		for (int i = 0; i < 3; i++) begin
			off_new[i] = {local_pos[i][31], local_pos[i]} - {lead_q[i][31], lead_q[i]};
			tsum[i]    = {{2{lead_q[i][31]}}, lead_q[i]} + {off_q[i][32], off_q[i]};
			target[i]  = sat32(tsum[i]);
		end
	end

	ffc_arrival u_arrival (
		.local_pos (local_pos),
		.target    (target),
		.tol       (tol_q),
		.near      (near)
	);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (!is_tick) begin
			unique case (mode_q)
				ffc_pkg::MODE_IDLE: begin
					if (cmd.leader_locked) mode_d = ffc_pkg::MODE_WAIT;
				end
				ffc_pkg::MODE_WAIT: begin
					if (steady_upd) mode_d = cap_q ? ffc_pkg::MODE_MOVE : ffc_pkg::MODE_IDLE;
				end
				ffc_pkg::MODE_MOVE, ffc_pkg::MODE_HOLD: begin
					if (cmd.leader_locked && !cmd.leader_at_goal) mode_d = ffc_pkg::MODE_WAIT;
				end
			endcase
		end else if (emit && mode_q == ffc_pkg::MODE_MOVE && cap_q && near) begin
			mode_d = ffc_pkg::MODE_HOLD;
		end
	end

	// Offset capture, setpoint and the result item.
	always_comb begin
		capture = emit && mode_q == ffc_pkg::MODE_IDLE && steady_st;
		sp      = emit && cap_q &&
			(mode_q == ffc_pkg::MODE_MOVE || mode_q == ffc_pkg::MODE_HOLD);
		cap_d   = cap_q || capture;
		res.mode           = mode_d;
		res.setpoint_valid = sp;
		res.target_x       = sp ? target[0] : 32'd0;
		res.target_y       = sp ? target[1] : 32'd0;
		res.target_z       = sp ? target[2] : 32'd0;
		res.offset_held    = cap_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ffc_pkg::MODE_IDLE;
			tol_q  <= ffc_pkg::TOL_RESET;
			seen_q <= 1'b0;
			lock_q <= 1'b0;
			goal_q <= 1'b0;
			cap_q  <= 1'b0;
		end else begin
			if (cfg_wr) tol_q <= cfg_data;
			if (commit) begin
				mode_q <= mode_d;
				cap_q  <= cap_d;
				if (!is_tick) begin
					seen_q <= 1'b1;
					lock_q <= cmd.leader_locked;
					goal_q <= cmd.leader_at_goal;
				end
			end
		end
	end

	// Leader position and offset; each is read only once its flag is set.
	always_ff @(posedge clk) begin
		if (commit && !is_tick) lead_q <= {cmd.leader_z, cmd.leader_y, cmd.leader_x};
		if (commit && capture) begin
			for (int i = 0; i < 3; i++) off_q[i] <= off_new[i];
		end
	end

endmodule

`default_nettype wire

### rtl/ffc_checker.sv
// Port-level checks on the result channel of the formation follower controller.
`timescale 1ns / 1ps
`default_nettype none

module ffc_port_checks (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input ffc_pkg::res_t res
);

	// A stalled result item stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// Without a setpoint the target fields are zero.
	a_no_sp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.setpoint_valid |->
		res.target_x == 32'd0 && res.target_y == 32'd0 && res.target_z == 32'd0)
		else $error("target fields set without a setpoint");

	// A setpoint needs a captured offset and a following mode.
	a_sp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.setpoint_valid |-> res.offset_held &&
		(res.mode == ffc_pkg::MODE_MOVE || res.mode == ffc_pkg::MODE_HOLD))
		else $error("setpoint outside move or hold, or without an offset");

endmodule

bind formation_follower_controller ffc_port_checks u_ffc_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
